// ===== design/spatial_audio_gain_pan_core_macros.svh =====
// Assertion macros for the spatial audio gain and pan core.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef SPATIAL_AUDIO_GAIN_PAN_CORE_MACROS_SVH
`define SPATIAL_AUDIO_GAIN_PAN_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SAGP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sagp assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SAGP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sagp assertion failed");
`else
`define SAGP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SAGP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/sagp_pkg.sv =====
// Shared types and constants for the spatial audio gain and pan core.
// No dependencies; used by every module of the block.
`default_nettype none

package sagp_pkg;

    // Field widths
    localparam int POS_W      = 32;
    localparam int FADE_W     = 31;
    localparam int GAIN_W     = 16;
    localparam int PAN_W      = 16;
    localparam int QUAT_W     = 16;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Internal widths
    localparam int DIFF_W     = POS_W + 1;
    localparam int SQ_RAD_W   = 2 * DIFF_W;
    localparam int DIST_W     = SQ_RAD_W / 2;
    localparam int EAR_W      = 20;
    localparam int DIV_Q_W    = 16;
    localparam int RDIV_DVD_W = FADE_W + DIV_Q_W;
    localparam int RDIV_DVS_W = FADE_W;
    localparam int PDIV_DVD_W = DIST_W + 15;
    localparam int PDIV_DVS_W = DIST_W;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_LISTENER_X = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LISTENER_Y = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LISTENER_Z = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_QUAT_W     = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_QUAT_X     = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_QUAT_Y     = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_QUAT_Z     = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SWAP       = 4'd7;

    // Distance factor classes
    localparam logic [1:0] TCLS_DIV  = 2'd0;
    localparam logic [1:0] TCLS_FULL = 2'd1;
    localparam logic [1:0] TCLS_ZERO = 2'd2;

    // Fixed-point constants
    localparam logic signed [QUAT_W-1:0] QUAT_ONE = 16'sd16384;
    localparam logic [16:0]              T_ONE    = 17'd65536;
    localparam logic [14:0]              PAN_MAX  = 15'd16384;
    localparam logic [15:0]              FAC_HALF = 16'd16384;
    localparam logic [16:0]              GAIN_SAT = 17'd65535;
    localparam logic signed [PAN_W-1:0]  PAN_HI   = 16'sd16384;
    localparam logic signed [PAN_W-1:0]  PAN_LO   = -16'sd16384;

    typedef struct packed {
        logic signed [POS_W-1:0] src_x;
        logic signed [POS_W-1:0] src_y;
        logic signed [POS_W-1:0] src_z;
        logic [FADE_W-1:0]       fade_start;
        logic [FADE_W-1:0]       fade_stop;
        logic [GAIN_W-1:0]       base_gain;
    } t_in_item;

    typedef struct packed {
        logic [GAIN_W-1:0]       out_gain;
        logic signed [PAN_W-1:0] out_pan;
    } t_out_item;

    // Side data that rides along the square-root pipeline
    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        logic [FADE_W-1:0]        fade_start;
        logic [FADE_W-1:0]        fade_stop;
        logic [GAIN_W-1:0]        base_gain;
        logic                     bypass;
    } t_sq_tag;

    // Side data that rides along the distance-ratio divider
    typedef struct packed {
        logic [1:0]        t_class;
        logic [GAIN_W-1:0] base_gain;
        logic              bypass;
    } t_rdiv_tag;

    // Side data that rides along the pan divider
    typedef struct packed {
        logic dist_zero;
        logic ovf;
        logic neg;
    } t_pdiv_tag;

    localparam int SQ_TAG_W   = $bits(t_sq_tag);
    localparam int RDIV_TAG_W = $bits(t_rdiv_tag);
    localparam int PDIV_TAG_W = $bits(t_pdiv_tag);

endpackage

`default_nettype wire

// ===== design/sagp_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with side data.
// Depends on sagp_pkg for default widths.
`default_nettype none

module sagp_isqrt #(
    parameter int RAD_W = sagp_pkg::SQ_RAD_W,
    parameter int TAG_W = sagp_pkg::SQ_TAG_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [RAD_W-1:0]     i_radicand,
    input  logic [TAG_W-1:0]     i_tag,
    output logic                 o_valid,
    output logic [RAD_W/2-1:0]   o_root,
    output logic [TAG_W-1:0]     o_tag
);
    localparam int ROOT_W = RAD_W / 2;

    logic [ROOT_W-1:0] r_vld;
    logic [RAD_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [TAG_W-1:0]  r_tag  [ROOT_W];

    logic [RAD_W-1:0]  a_rem  [ROOT_W];
    logic [ROOT_W-1:0] a_root [ROOT_W];
    logic [RAD_W-1:0]  w_trial [ROOT_W];
    logic [ROOT_W-1:0] w_ge;
    logic [RAD_W-1:0]  n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];

    // Select each stage's source: the input or the stage before
    always_comb begin
        a_rem[0]  = i_radicand;
        a_root[0] = '0;
        for (int s = 1; s < ROOT_W; s++) begin
            a_rem[s]  = r_rem[s-1];
            a_root[s] = r_root[s-1];
        end
    end

    // Try one root bit per stage: keep it if the remainder covers 2*r*2^k + 4^k
    always_comb begin
        for (int s = 0; s < ROOT_W; s++) begin
            w_trial[s] = (RAD_W'(a_root[s]) << (ROOT_W - s))
                       | (RAD_W'(1) << (2 * (ROOT_W - 1 - s)));
            w_ge[s]    = a_rem[s] >= w_trial[s];
            n_rem[s]   = w_ge[s] ? (a_rem[s] - w_trial[s]) : a_rem[s];
            n_root[s]  = a_root[s];
            n_root[s][ROOT_W-1-s] = w_ge[s];
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ROOT_W-2:0], i_valid};
        end
    end

    // Advance stage data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int s = 0; s < ROOT_W; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
            end
            for (int s = 1; s < ROOT_W; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_tag   = r_tag[ROOT_W-1];

endmodule

`default_nettype wire

// ===== design/sagp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side data.
// The dividend must stay below divisor * 2^Q_W. Depends on sagp_pkg for defaults.
`default_nettype none

module sagp_div #(
    parameter int DVD_W = sagp_pkg::RDIV_DVD_W,
    parameter int DVS_W = sagp_pkg::RDIV_DVS_W,
    parameter int Q_W   = sagp_pkg::DIV_Q_W,
    parameter int TAG_W = sagp_pkg::RDIV_TAG_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quot,
    output logic [TAG_W-1:0] o_tag
);
    localparam int CMP_W = (DVD_W > DVS_W + Q_W) ? DVD_W : DVS_W + Q_W;

    logic [Q_W-1:0]   r_vld;
    logic [DVD_W-1:0] r_rem  [Q_W];
    logic [DVS_W-1:0] r_dvs  [Q_W];
    logic [Q_W-1:0]   r_quot [Q_W];
    logic [TAG_W-1:0] r_tag  [Q_W];

    logic [DVD_W-1:0] a_rem  [Q_W];
    logic [DVS_W-1:0] a_dvs  [Q_W];
    logic [Q_W-1:0]   a_quot [Q_W];
    logic [CMP_W-1:0] w_trial [Q_W];
    logic [Q_W-1:0]   w_ge;
    logic [DVD_W-1:0] n_rem  [Q_W];
    logic [Q_W-1:0]   n_quot [Q_W];

    // Select each stage's source: the input or the stage before
    always_comb begin
        a_rem[0]  = i_dividend;
        a_dvs[0]  = i_divisor;
        a_quot[0] = '0;
        for (int s = 1; s < Q_W; s++) begin
            a_rem[s]  = r_rem[s-1];
            a_dvs[s]  = r_dvs[s-1];
            a_quot[s] = r_quot[s-1];
        end
    end

    // Subtract the shifted divisor where it fits and set that quotient bit
    always_comb begin
        for (int s = 0; s < Q_W; s++) begin
            w_trial[s] = CMP_W'(a_dvs[s]) << (Q_W - 1 - s);
            w_ge[s]    = CMP_W'(a_rem[s]) >= w_trial[s];
            n_rem[s]   = w_ge[s] ? DVD_W'(CMP_W'(a_rem[s]) - w_trial[s]) : a_rem[s];
            n_quot[s]  = a_quot[s];
            n_quot[s][Q_W-1-s] = w_ge[s];
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Q_W-2:0], i_valid};
        end
    end

    // Advance stage data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int s = 0; s < Q_W; s++) begin
                r_rem[s]  <= n_rem[s];
                r_dvs[s]  <= a_dvs[s];
                r_quot[s] <= n_quot[s];
            end
            for (int s = 1; s < Q_W; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quot  = r_quot[Q_W-1];
    assign o_tag   = r_tag[Q_W-1];

endmodule

`default_nettype wire

// ===== design/spatial_audio_gain_pan_core.sv =====
// Top level of the spatial audio gain and pan core: distance fade and stereo pan.
// Depends on sagp_pkg, sagp_isqrt, sagp_div and the assertion macro header.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | i_in_valid, o_in_stall, i_in_data    | source request in
//   out     | o_out_valid, i_out_stall, o_out_data | result request out
//   cfg     | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | register write
//
// One source request enters per cycle while o_in_stall is low.
// Depth is set by the 33-stage square root and the 16-stage dividers behind it.
// Synchronous active-low reset clears valid bits and loads register defaults.
// An output register plus a skid entry take results; the pipeline freezes
// only while the skid entry is full, and o_in_stall follows that entry.
`default_nettype none
`include "spatial_audio_gain_pan_core_macros.svh"

module spatial_audio_gain_pan_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sagp_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sagp_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sagp_pkg::CFG_ADDR_W-1:0]     i_cfg_index,
    input  logic [sagp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sagp_pkg::*;

    // Configuration registers
    logic signed [POS_W-1:0]  r_lis_x, r_lis_y, r_lis_z;
    logic signed [QUAT_W-1:0] r_qw, r_qx, r_qy, r_qz;
    logic                     r_swap;

    // Ear axis pipeline
    logic signed [31:0]      r_p_ww, r_p_xx, r_p_yy, r_p_zz, r_p_xy, r_p_wz, r_p_xz, r_p_wy;
    logic signed [33:0]      r_sx, r_sy, r_sz;
    logic signed [EAR_W-1:0] r_ex, r_ey, r_ez;

    // Pipeline control
    logic w_en;
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v, r10_v, r11_v, r12_v;

    // Front stages
    t_sq_tag               r1_tag, r2_tag, r3_tag, r4_tag;
    logic [DIFF_W-1:0]     r2_ax, r2_ay, r2_az;
    logic [SQ_RAD_W-1:0]   r3_sqx, r3_sqy, r3_sqz;
    logic [SQ_RAD_W-1:0]   r4_rad;

    // Square root outputs
    logic                  w_sq_v;
    logic [DIST_W-1:0]     w_d;
    t_sq_tag               w_sq_tag;

    // Middle stages
    logic signed [34:0]    r5_num;
    logic signed [31:0]    r5_den;
    logic signed [52:0]    r5_px, r5_py, r5_pz;
    logic [DIST_W-1:0]     r5_d, r6_d, r7_d;
    logic [GAIN_W-1:0]     r5_vol, r6_vol, r7_vol, r8_vol;
    logic                  r5_byp, r6_byp, r7_byp, r8_byp;
    logic                  r5_dz, r6_dz, r7_dz, r8_dz;
    logic signed [34:0]    r6_num;
    logic [FADE_W-1:0]     r6_den, r7_den, r8_den;
    logic signed [54:0]    r6_dot;
    logic [1:0]            r7_cls, r8_cls;
    logic [FADE_W-1:0]     r7_num;
    logic [54:0]           r7_adot;
    logic                  r7_neg, r8_neg;
    logic                  r8_ovf;
    logic [RDIV_DVD_W-1:0] r8_rdvd;
    logic [PDIV_DVD_W-1:0] r8_pdvd;
    logic [DIST_W-1:0]     r8_d;
    t_rdiv_tag             w_rdiv_tag_in, w_rdiv_tag;
    t_pdiv_tag             w_pdiv_tag_in, w_pdiv_tag;
    logic                  w_rdiv_v, w_pdiv_v;
    logic [DIV_Q_W-1:0]    w_rdiv_q, w_pdiv_q;

    // Back stages
    logic [16:0]             r9_t;
    logic [15:0]             r9_fac, r10_fac;
    logic signed [PAN_W-1:0] r9_pan, r10_pan, r11_pan;
    logic [GAIN_W-1:0]       r9_vol, r10_vol, r11_vol;
    logic                    r9_byp, r10_byp, r11_byp;
    logic [16:0]             r10_tt;
    logic [31:0]             r11_ft;
    t_out_item               r12_out;
    logic [14:0]             w_mag;
    logic [15:0]             w_mag16;
    logic [16:0]             w_t;
    logic [33:0]             w_tsq;
    logic [47:0]             w_g48;
    logic [16:0]             w_g;

    // Output register and skid entry
    t_out_item r_out, r_skid;
    logic      r_out_v, r_skid_v;

    // Divide by 2^14 truncating toward zero
    function automatic logic signed [EAR_W-1:0] trunc_q14(input logic signed [33:0] v);
        logic signed [33:0] adj;
        adj = v + (v[33] ? 34'sd16383 : 34'sd0);
        return EAR_W'(adj >>> 14);
    endfunction

    // Write configuration registers; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lis_x <= '0;
            r_lis_y <= '0;
            r_lis_z <= '0;
            r_qw    <= QUAT_ONE;
            r_qx    <= '0;
            r_qy    <= '0;
            r_qz    <= '0;
            r_swap  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LISTENER_X: r_lis_x <= signed'(i_cfg_data);
                CFG_LISTENER_Y: r_lis_y <= signed'(i_cfg_data);
                CFG_LISTENER_Z: r_lis_z <= signed'(i_cfg_data);
                CFG_QUAT_W:     r_qw    <= signed'(i_cfg_data[QUAT_W-1:0]);
                CFG_QUAT_X:     r_qx    <= signed'(i_cfg_data[QUAT_W-1:0]);
                CFG_QUAT_Y:     r_qy    <= signed'(i_cfg_data[QUAT_W-1:0]);
                CFG_QUAT_Z:     r_qz    <= signed'(i_cfg_data[QUAT_W-1:0]);
                CFG_SWAP:       r_swap  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Rotate the ear axis from the quaternion: products, sums, then scale to Q14
    always_ff @(posedge i_clk) begin
        r_p_ww <= 32'(r_qw) * 32'(r_qw);
        r_p_xx <= 32'(r_qx) * 32'(r_qx);
        r_p_yy <= 32'(r_qy) * 32'(r_qy);
        r_p_zz <= 32'(r_qz) * 32'(r_qz);
        r_p_xy <= 32'(r_qx) * 32'(r_qy);
        r_p_wz <= 32'(r_qw) * 32'(r_qz);
        r_p_xz <= 32'(r_qx) * 32'(r_qz);
        r_p_wy <= 32'(r_qw) * 32'(r_qy);
        r_sx   <= 34'(r_p_ww) + 34'(r_p_xx) - 34'(r_p_yy) - 34'(r_p_zz);
        r_sy   <= (34'(r_p_xy) + 34'(r_p_wz)) <<< 1;
        r_sz   <= (34'(r_p_xz) - 34'(r_p_wy)) <<< 1;
        r_ex   <= trunc_q14(r_sx);
        r_ey   <= trunc_q14(r_sy);
        r_ez   <= trunc_q14(r_sz);
    end

    // Freeze the pipeline only while the skid entry is occupied
    assign w_en       = !r_skid_v;
    assign o_in_stall = r_skid_v;

    // Advance valid bits outside the submodules
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r12_v <= 1'b0;
        end else if (w_en) begin
            r1_v  <= i_in_valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r5_v  <= w_sq_v;
            r6_v  <= r5_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= w_rdiv_v;
            r10_v <= r9_v;
            r11_v <= r10_v;
            r12_v <= r11_v;
        end
    end

    // Front: differences, magnitudes, squares, sum of squares
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_tag.dx         <= DIFF_W'(i_in_data.src_x) - DIFF_W'(r_lis_x);
            r1_tag.dy         <= DIFF_W'(i_in_data.src_y) - DIFF_W'(r_lis_y);
            r1_tag.dz         <= DIFF_W'(i_in_data.src_z) - DIFF_W'(r_lis_z);
            r1_tag.fade_start <= i_in_data.fade_start;
            r1_tag.fade_stop  <= i_in_data.fade_stop;
            r1_tag.base_gain  <= i_in_data.base_gain;
            r1_tag.bypass     <= i_in_data.fade_start == i_in_data.fade_stop;

            r2_tag <= r1_tag;
            r2_ax  <= r1_tag.dx[DIFF_W-1] ? DIFF_W'(-r1_tag.dx) : DIFF_W'(r1_tag.dx);
            r2_ay  <= r1_tag.dy[DIFF_W-1] ? DIFF_W'(-r1_tag.dy) : DIFF_W'(r1_tag.dy);
            r2_az  <= r1_tag.dz[DIFF_W-1] ? DIFF_W'(-r1_tag.dz) : DIFF_W'(r1_tag.dz);

            r3_tag <= r2_tag;
            r3_sqx <= SQ_RAD_W'(r2_ax) * SQ_RAD_W'(r2_ax);
            r3_sqy <= SQ_RAD_W'(r2_ay) * SQ_RAD_W'(r2_ay);
            r3_sqz <= SQ_RAD_W'(r2_az) * SQ_RAD_W'(r2_az);

            r4_tag <= r3_tag;
            r4_rad <= r3_sqx + r3_sqy + r3_sqz;
        end
    end

    sagp_isqrt #(
        .RAD_W (SQ_RAD_W),
        .TAG_W (SQ_TAG_W)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r4_v),
        .i_radicand (r4_rad),
        .i_tag      (r4_tag),
        .o_valid    (w_sq_v),
        .o_root     (w_d),
        .o_tag      (w_sq_tag)
    );

    // Middle: fade ratio terms, dot product, classification, pan overflow
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_num <= signed'({2'b00, w_d}) - signed'({4'b0000, w_sq_tag.fade_start});
            r5_den <= signed'({1'b0, w_sq_tag.fade_stop})
                    - signed'({1'b0, w_sq_tag.fade_start});
            r5_px  <= 53'(r_ex) * 53'($signed(w_sq_tag.dx));
            r5_py  <= 53'(r_ey) * 53'($signed(w_sq_tag.dy));
            r5_pz  <= 53'(r_ez) * 53'($signed(w_sq_tag.dz));
            r5_d   <= w_d;
            r5_vol <= w_sq_tag.base_gain;
            r5_byp <= w_sq_tag.bypass;
            r5_dz  <= w_d == '0;

            // Flip both terms when the fade runs backward
            if (r5_den[31]) begin
                r6_num <= -r5_num;
                r6_den <= FADE_W'(-r5_den);
            end else begin
                r6_num <= r5_num;
                r6_den <= r5_den[FADE_W-1:0];
            end
            r6_dot <= 55'(r5_px) + 55'(r5_py) + 55'(r5_pz);
            r6_d   <= r5_d;
            r6_vol <= r5_vol;
            r6_byp <= r5_byp;
            r6_dz  <= r5_dz;

            if (r6_num <= 35'sd0) begin
                r7_cls <= TCLS_FULL;
            end else if (r6_num >= signed'({4'b0000, r6_den})) begin
                r7_cls <= TCLS_ZERO;
            end else begin
                r7_cls <= TCLS_DIV;
            end
            r7_num  <= r6_num[FADE_W-1:0];
            r7_den  <= r6_den;
            r7_adot <= r6_dot[54] ? unsigned'(-r6_dot) : unsigned'(r6_dot);
            r7_neg  <= r6_dot[54];
            r7_d    <= r6_d;
            r7_vol  <= r6_vol;
            r7_byp  <= r6_byp;
            r7_dz   <= r6_dz;

            r8_ovf  <= r7_adot >= {7'b0, r7_d, 15'b0};
            r8_pdvd <= r7_adot[PDIV_DVD_W-1:0];
            r8_rdvd <= (r7_cls == TCLS_DIV) ? {r7_num, 16'b0} : '0;
            r8_den  <= r7_den;
            r8_d    <= r7_d;
            r8_cls  <= r7_cls;
            r8_neg  <= r7_neg;
            r8_vol  <= r7_vol;
            r8_byp  <= r7_byp;
            r8_dz   <= r7_dz;
        end
    end

    assign w_rdiv_tag_in.t_class   = r8_cls;
    assign w_rdiv_tag_in.base_gain = r8_vol;
    assign w_rdiv_tag_in.bypass    = r8_byp;
    assign w_pdiv_tag_in.dist_zero = r8_dz;
    assign w_pdiv_tag_in.ovf       = r8_ovf;
    assign w_pdiv_tag_in.neg       = r8_neg;

    sagp_div #(
        .DVD_W (RDIV_DVD_W),
        .DVS_W (RDIV_DVS_W),
        .Q_W   (DIV_Q_W),
        .TAG_W (RDIV_TAG_W)
    ) u_rdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r8_v),
        .i_dividend (r8_rdvd),
        .i_divisor  (r8_den),
        .i_tag      (w_rdiv_tag_in),
        .o_valid    (w_rdiv_v),
        .o_quot     (w_rdiv_q),
        .o_tag      (w_rdiv_tag)
    );

    sagp_div #(
        .DVD_W (PDIV_DVD_W),
        .DVS_W (PDIV_DVS_W),
        .Q_W   (DIV_Q_W),
        .TAG_W (PDIV_TAG_W)
    ) u_pdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r8_v),
        .i_dividend (r8_pdvd),
        .i_divisor  (r8_d),
        .i_tag      (w_pdiv_tag_in),
        .o_valid    (w_pdiv_v),
        .o_quot     (w_pdiv_q),
        .o_tag      (w_pdiv_tag)
    );

    // Pick the distance factor and the clamped pan magnitude
    always_comb begin
        case (w_rdiv_tag.t_class)
            TCLS_FULL: w_t = T_ONE;
            TCLS_ZERO: w_t = '0;
            default:   w_t = T_ONE - {1'b0, w_rdiv_q};
        endcase
        if (w_pdiv_tag.dist_zero) begin
            w_mag = '0;
        end else if (w_pdiv_tag.ovf || (w_pdiv_q > {1'b0, PAN_MAX})) begin
            w_mag = PAN_MAX;
        end else begin
            w_mag = w_pdiv_q[14:0];
        end
        w_mag16 = {1'b0, w_mag};
        w_tsq   = 34'(r9_t) * 34'(r9_t);
        w_g48   = 48'(r11_ft) * 48'(r11_vol);
        w_g     = w_g48[47:31];
    end

    // Back: square the factor, scale by the pan weight, then by the base gain
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_t   <= w_t;
            r9_fac <= FAC_HALF + w_mag16;
            r9_pan <= (w_pdiv_tag.neg ^ r_swap) ? signed'(16'd0 - w_mag16) : signed'(w_mag16);
            r9_vol <= w_rdiv_tag.base_gain;
            r9_byp <= w_rdiv_tag.bypass;

            r10_tt  <= w_tsq[32:16];
            r10_fac <= r9_fac;
            r10_pan <= r9_pan;
            r10_vol <= r9_vol;
            r10_byp <= r9_byp;

            r11_ft  <= 32'(r10_fac) * 32'(r10_tt);
            r11_pan <= r10_pan;
            r11_vol <= r10_vol;
            r11_byp <= r10_byp;

            if (r11_byp) begin
                r12_out.out_gain <= r11_vol;
                r12_out.out_pan  <= '0;
            end else begin
                r12_out.out_gain <= (w_g > GAIN_SAT) ? GAIN_SAT[15:0] : w_g[15:0];
                r12_out.out_pan  <= r11_pan;
            end
        end
    end

    // Hold the output request; park the pipeline tail in the skid entry on a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_out_stall) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= r12_v;
            end
        end else if (r12_v && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_out_stall) begin
            r_out <= r_skid_v ? r_skid : r12_out;
        end else if (!r_skid_v) begin
            r_skid <= r12_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    `SAGP_ASSERT_IMPLY(a_skid_needs_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `SAGP_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_v && !i_out_stall, !r_skid_v)
    `SAGP_ASSERT_IMPLY(a_div_lockstep, i_clk, i_rst_n, w_rdiv_v || w_pdiv_v, w_rdiv_v && w_pdiv_v)
    `SAGP_ASSERT_IMPLY(a_pan_range, i_clk, i_rst_n, o_out_valid, ($signed(o_out_data.out_pan) <= PAN_HI) && ($signed(o_out_data.out_pan) >= PAN_LO))

endmodule

`default_nettype wire

// ===== tb/tb_spatial_audio_gain_pan_core.sv =====
// Self-checking testbench for spatial_audio_gain_pan_core: distance fade and stereo pan.
// Depends on sagp_pkg and the core RTL; drives source requests and register writes and
// checks every result against a local fixed-point predictor or a directed expected value.
`default_nettype none

module tb_spatial_audio_gain_pan_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sagp_pkg::*;

    localparam int  LATENCY   = 62;
    localparam int  LIMIT     = 2000000;
    localparam int  PHASE_LEN = 150;
    localparam int  NUM_DIR   = 10;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 4'd9;

    typedef struct packed {
        t_in_item  src;
        logic      known;
        t_out_item res;
    } t_dir_row;

    // Directed sources; the listener sits at the origin facing the default way
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        // equal fade distances pass the volume through
        '{'{32'sd0, 32'sd0, 32'sd0, 31'h100000, 31'h100000, 16'hffff}, 1'b1, '{16'hffff, 16'sd0}},
        '{'{32'sd5, 32'sd7, 32'sd9, 31'h7fffffff, 31'h7fffffff, 16'h0}, 1'b1, '{16'h0, 16'sd0}},
        // source on the listener: no pan, half gain
        '{'{32'sd0, 32'sd0, 32'sd0, 31'h640000, 31'hc80000, 16'd16384}, 1'b1, '{16'd8192, 16'sd0}},
        // past the fade stop: silent, full right
        '{'{32'sh3e80000, 32'sd0, 32'sd0, 31'h0, 31'ha0000, 16'd40000}, 1'b1,
          '{16'd0, 16'sd16384}},
        // inside the fade start, hard right and hard left
        '{'{32'sh10000, 32'sd0, 32'sd0, 31'ha0000, 31'h140000, 16'hffff}, 1'b1,
          '{16'hffff, 16'sd16384}},
        '{'{-32'sh10000, 32'sd0, 32'sd0, 31'ha0000, 31'h140000, 16'hffff}, 1'b1,
          '{16'hffff, -16'sd16384}},
        // fade stop below fade start
        '{'{32'shf0000, 32'sd0, 32'sd0, 31'h140000, 31'ha0000, 16'd16384}, 1'b0, '0},
        // field extremes
        '{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h0, 31'h7fffffff, 16'hffff},
          1'b0, '0},
        '{'{32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff, 31'h1, 16'hffff},
          1'b0, '0},
        // straight ahead: no pan
        '{'{32'sd0, 32'sh50000, 32'sd0, 31'h10000, 31'h90000, 16'h1234}, 1'b0, '0}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Listener registers as the predictor sees them
    logic signed [POS_W-1:0]  lis_x, lis_y, lis_z;
    logic signed [QUAT_W-1:0] q_w, q_x, q_y, q_z;
    logic                     swap_lr;

    t_out_item pending_results [$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        hold_len = 0;
    int        cycles = 0;

    spatial_audio_gain_pan_core dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Gain and pan of one source for the current listener
    function automatic t_out_item gain_pan_of(t_in_item s);
        logic signed [69:0] dx, dy, dz;
        logic [69:0]        sq;
        logic [34:0]        d, c;
        longint             num, den, t, tt, ex, ey, ez, pan, fac, g;
        t_out_item          r;
        if (s.fade_start == s.fade_stop) begin
            r.out_gain = s.base_gain;
            r.out_pan  = '0;
            return r;
        end
        dx = 70'(s.src_x) - 70'(lis_x);
        dy = 70'(s.src_y) - 70'(lis_y);
        dz = 70'(s.src_z) - 70'(lis_z);
        sq = dx * dx + dy * dy + dz * dz;
        d = '0;
        for (int k = 34; k >= 0; k--) begin
            c = d | (35'd1 << k);
            if (70'(c) * 70'(c) <= sq) d = c;
        end
        num = longint'(d) - longint'(s.fade_start);
        den = longint'(s.fade_stop) - longint'(s.fade_start);
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (num <= 0) t = 65536;
        else if (num >= den) t = 0;
        else t = 65536 - (num * 65536) / den;
        tt = (t * t) >>> 16;
        ex = (longint'(q_w) * q_w + longint'(q_x) * q_x - longint'(q_y) * q_y
              - longint'(q_z) * q_z) / 16384;
        ey = (2 * (longint'(q_x) * q_y + longint'(q_w) * q_z)) / 16384;
        ez = (2 * (longint'(q_x) * q_z - longint'(q_w) * q_y)) / 16384;
        if (d == 0) begin
            pan = 0;
        end else begin
            pan = (ex * longint'(dx) + ey * longint'(dy) + ez * longint'(dz)) / longint'(d);
            if (pan > 16384) pan = 16384;
            if (pan < -16384) pan = -16384;
            if (swap_lr) pan = -pan;
        end
        fac = 16384 + (pan < 0 ? -pan : pan);
        g = (fac * tt * longint'(s.base_gain)) >>> 31;
        if (g > 65535) g = 65535;
        r.out_gain = g[15:0];
        r.out_pan  = pan[15:0];
        return r;
    endfunction

    // Random source: mostly near the listener with fade distances of matching scale
    function automatic t_in_item random_source();
        t_in_item s;
        int       sh;
        s.src_x      = $urandom;
        s.src_y      = $urandom;
        s.src_z      = $urandom;
        s.fade_start = 31'($urandom);
        s.fade_stop  = 31'($urandom);
        s.base_gain  = 16'($urandom);
        case ($urandom_range(9))
            0: ;
            1: s.fade_stop = s.fade_start;
            2: begin
                s.src_x = lis_x;
                s.src_y = lis_y;
                s.src_z = lis_z;
            end
            default: begin
                sh = $urandom_range(24, 4);
                s.src_x = lis_x + ($signed($urandom) >>> sh);
                s.src_y = lis_y + ($signed($urandom) >>> sh);
                s.src_z = lis_z + ($signed($urandom) >>> sh);
                s.fade_start = 31'($urandom >> (sh + $urandom_range(2)));
                s.fade_stop  = 31'($urandom >> (sh + $urandom_range(2)));
            end
        endcase
        return s;
    endfunction

    // Offer one source request, holding it until accepted, and record its result
    task automatic send_source(t_in_item s, logic known, t_out_item res);
        int gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(known ? res : gain_pan_of(s));
    endtask

    // Write one register; the caller lowers the valid after its last write
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_LISTENER_X: lis_x = val;
            CFG_LISTENER_Y: lis_y = val;
            CFG_LISTENER_Z: lis_z = val;
            CFG_QUAT_W:     q_w = val[15:0];
            CFG_QUAT_X:     q_x = val[15:0];
            CFG_QUAT_Y:     q_y = val[15:0];
            CFG_QUAT_Z:     q_z = val[15:0];
            CFG_SWAP:       swap_lr = val[0];
            default: ;
        endcase
    endtask

    // Drain the pipeline and reload the listener
    task automatic load_listener(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                 logic [15:0] w, logic [15:0] x, logic [15:0] y,
                                 logic [15:0] z, logic swp);
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
        write_reg(CFG_LISTENER_X, px);
        write_reg(CFG_LISTENER_Y, py);
        write_reg(CFG_LISTENER_Z, pz);
        write_reg(CFG_QUAT_W, {16'h0, w});
        write_reg(CFG_QUAT_X, {16'h0, x});
        write_reg(CFG_QUAT_Y, {16'h0, y});
        write_reg(CFG_QUAT_Z, {16'h0, z});
        write_reg(CFG_SWAP, {31'h0, swp});
        write_reg(CFG_UNUSED, $urandom);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) send_source(random_source(), 1'b0, '0);
    endtask

    // Receiver stall, with an occasional long hold-off
    initial begin
        int held;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                held = hold_len;
                hold_len = 0;
            end
            if (held > 0) begin
                held--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Compare each accepted result with the oldest pending one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result gain=%0d pan=%0d",
                             o_out_data.out_gain, o_out_data.out_pan);
            end else begin
                t_out_item want;
                want = pending_results.pop_front();
                if (want.out_gain !== o_out_data.out_gain
                        || want.out_pan !== o_out_data.out_pan) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected gain=%0d pan=%0d, got gain=%0d pan=%0d",
                                 want.out_gain, want.out_pan,
                                 o_out_data.out_gain, o_out_data.out_pan);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        lis_x = '0; lis_y = '0; lis_z = '0;
        q_w = QUAT_ONE; q_x = '0; q_y = '0; q_z = '0;
        swap_lr = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sources at reset settings
        foreach (DIR_ROWS[i]) send_source(DIR_ROWS[i].src, DIR_ROWS[i].known, DIR_ROWS[i].res);

        // No idling, then a long receiver hold-off while sources keep coming
        run_random(PHASE_LEN / 2);
        hold_len = 400;
        run_random(PHASE_LEN / 2);

        // Rotated a quarter turn about z, swapped; sender idles
        load_listener($urandom, $urandom, $urandom, 16'd11585, 16'd0, 16'd0, 16'd11585, 1'b1);
        send_idle_pct = 86;
        run_random(PHASE_LEN);

        // Extreme listener and most negative quaternion; receiver stalls
        load_listener(32'h7fffffff, 32'h80000000, 32'h0,
                      16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_idle_pct = 0;
        stall_pct = 86;
        run_random(PHASE_LEN / 2);
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        run_random(PHASE_LEN / 2);

        // Largest quaternion, swapped; both sides idle lightly
        load_listener($urandom >> 8, -($urandom >> 8), $urandom >> 12,
                      16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
        send_idle_pct = 12;
        stall_pct = 12;
        run_random(PHASE_LEN);

        // Fully random listener
        load_listener($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 1'($urandom_range(1)));
        send_idle_pct = 0;
        stall_pct = 0;
        run_random(PHASE_LEN);

        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
